// ----- hw/rtl/gbn_pkg.sv -----
`default_nettype none

package gbn_pkg;

  localparam int SEQ_W  = 24;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 17;
  localparam int SIZE_W = 32;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  // Upper bound on send requests per event
  localparam int MAX_OUT = 8;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_NACK    = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REMAIN,
    ST_DECIDE,
    ST_OFFSET,
    ST_SEND,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/go_back_n_sender_core.sv -----
`default_nettype none

// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// input     | in_valid / in_stall    | opcode, ack_seq
// output    | out_valid / out_stall  | kind, seq, byte_offset, length, last
// config    | cfg_valid / cfg_ready  | file_size
//
// Each input transaction runs one at a time. The record count comes from
// file_size / PAYLOAD_BYTES: a reciprocal multiply in DIVIDE, the remainder on
// the shared multiply-by-PAYLOAD_BYTES unit in REMAIN, then a decision in DECIDE.
// An event gives no result, a done result, or n send requests (up to
// min(WINDOW, 8)); before the sends, OFFSET forms the first offset on that unit.
// Output stalls simply hold the SEND/FINISH sequencer; the final result may sit
// in the output register while the next input transaction is accepted.
// rst is synchronous, active high, and clears control state and file_size.

module go_back_n_sender_core #(
  parameter int PAYLOAD_BYTES = 512,
  parameter int WINDOW        = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  // event input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   opcode,
  input  wire logic [gbn_pkg::SEQ_W-1:0]    ack_seq,

  // result output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              kind,
  output logic [gbn_pkg::SEQ_W-1:0]         seq,
  output logic [gbn_pkg::OFF_W-1:0]         byte_offset,
  output logic [gbn_pkg::LEN_W-1:0]         length,
  output logic                              last,

  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gbn_pkg::SIZE_W-1:0]   file_size
);

  // Remainder width: remainder is always below PAYLOAD_BYTES
  localparam int RW      = $clog2(PAYLOAD_BYTES);
  localparam int LIM     = (WINDOW < gbn_pkg::MAX_OUT) ? WINDOW : gbn_pkg::MAX_OUT;
  localparam int CNT_W   = $clog2(gbn_pkg::MAX_OUT);
  localparam int PROD_W  = 2 * gbn_pkg::SIZE_W + 1;

  // ceil(2^(32+RW) / PAYLOAD_BYTES): (x * RECIP) >> (32+RW) is exact for 32-bit x
  localparam longint unsigned RECIP_L =
    ((64'd1 << (gbn_pkg::SIZE_W + RW)) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES);

  localparam logic [gbn_pkg::SIZE_W:0]     RECIP   = (gbn_pkg::SIZE_W+1)'(RECIP_L);
  localparam logic [gbn_pkg::OFF_W-1:0]    PAY_OFF = gbn_pkg::OFF_W'(PAYLOAD_BYTES);
  localparam logic [gbn_pkg::LEN_W-1:0]    PAY_LEN = gbn_pkg::LEN_W'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0]             CNT_LAST = CNT_W'(LIM - 1);

  gbn_pkg::state_t state, state_next;

  // configuration register
  logic [gbn_pkg::SIZE_W-1:0] fsize;

  // latched event
  gbn_pkg::op_t              op;
  logic [gbn_pkg::SEQ_W-1:0] ack;

  // window state
  logic                      active;
  logic [gbn_pkg::SEQ_W-1:0] last_acked;
  logic [gbn_pkg::SEQ_W-1:0] last_sent;

  // divider
  logic [gbn_pkg::SIZE_W-1:0] quot;
  logic [RW-1:0]              rem;

  // per-event results of the decision
  logic [gbn_pkg::SEQ_W-1:0] rec_count;
  logic [gbn_pkg::LEN_W-1:0] fin_len;

  // send sequencer
  logic [gbn_pkg::SEQ_W-1:0] cur_seq;
  logic [gbn_pkg::OFF_W-1:0] cur_off;
  logic [CNT_W-1:0]          sent_cnt;

  // handshakes
  logic in_take;
  logic out_free;
  logic cfg_take;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_take = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------------
  // Divider: reciprocal multiply for the quotient, then the remainder on the
  // shared multiply-by-PAYLOAD_BYTES unit (also used for the first offset)
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]          quot_prod;
  logic [gbn_pkg::SIZE_W-1:0] quot_now;
  logic [gbn_pkg::SIZE_W-1:0] mul_a;
  logic [gbn_pkg::SIZE_W-1:0] mul_prod;
  logic [RW-1:0]              rem_now;

  always_comb begin
    quot_prod = PROD_W'(fsize) * PROD_W'(RECIP);
    quot_now  = gbn_pkg::SIZE_W'(quot_prod >> (gbn_pkg::SIZE_W + RW));
    mul_a     = (state == gbn_pkg::ST_REMAIN) ? quot :
                {{(gbn_pkg::SIZE_W - gbn_pkg::SEQ_W){1'b0}}, last_acked};
    mul_prod  = mul_a * PAY_OFF;
    rem_now   = RW'(fsize - mul_prod);
  end

  // ---------------------------------------------------------------------------
  // Decision: record count from quotient, then window bookkeeping
  // ---------------------------------------------------------------------------
  logic                      cnt_sat;
  logic [gbn_pkg::SEQ_W-1:0] cnt_now;
  logic [gbn_pkg::LEN_W-1:0] fin_len_now;
  logic [gbn_pkg::SEQ_W-1:0] la_new;
  logic                      la_we;
  logic                      dec_send;
  logic                      dec_finish;

  always_comb begin
    // count = q + 1, saturating at the largest sequence number
    cnt_sat     = (quot >= gbn_pkg::SIZE_W'(gbn_pkg::SEQ_MAX));
    cnt_now     = cnt_sat ? gbn_pkg::SEQ_MAX : quot[gbn_pkg::SEQ_W-1:0] + 1'b1;
    // final record: remainder, or a full record when the count saturated
    fin_len_now = cnt_sat ? PAY_LEN : gbn_pkg::LEN_W'(rem);

    la_new     = last_acked;
    la_we      = 1'b0;
    dec_send   = 1'b0;
    dec_finish = 1'b0;

    unique case (op)
      gbn_pkg::OP_START: begin
        la_new   = '0;
        la_we    = 1'b1;
        dec_send = 1'b1;
      end
      gbn_pkg::OP_ACK: begin
        if (active && (ack > last_acked)) begin
          la_new = ack;
          la_we  = 1'b1;
          if (ack >= cnt_now) begin
            dec_finish = 1'b1;
          end else if (ack == last_sent) begin
            dec_send = 1'b1;
          end
        end
      end
      gbn_pkg::OP_NACK: begin
        if (active) begin
          la_new = (ack != '0) ? ack - 1'b1 : '0;
          la_we  = 1'b1;
          if (la_new >= cnt_now) begin
            dec_finish = 1'b1;
          end else begin
            dec_send = 1'b1;
          end
        end
      end
      gbn_pkg::OP_TIMEOUT: begin
        if (active) begin
          if (last_acked >= cnt_now) begin
            dec_finish = 1'b1;
          end else begin
            dec_send = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // current send request is the file's final record (rec_final) or the final one of this event (rec_last)
  logic rec_final;
  logic rec_last;

  assign rec_final = (cur_seq == rec_count);
  assign rec_last  = rec_final || (sent_cnt == CNT_LAST);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;

    unique case (state)
      gbn_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (in_valid) begin
          state_next = gbn_pkg::ST_DIVIDE;
        end
      end
      gbn_pkg::ST_DIVIDE: begin
        state_next = gbn_pkg::ST_REMAIN;
      end
      gbn_pkg::ST_REMAIN: begin
        state_next = gbn_pkg::ST_DECIDE;
      end
      gbn_pkg::ST_DECIDE: begin
        priority if (dec_finish) begin
          state_next = gbn_pkg::ST_FINISH;
        end else if (dec_send) begin
          state_next = gbn_pkg::ST_OFFSET;
        end else begin
          state_next = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_OFFSET: begin
        state_next = gbn_pkg::ST_SEND;
      end
      gbn_pkg::ST_SEND: begin
        if (out_free && rec_last) begin
          state_next = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = gbn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fsize      <= '0;
      active     <= 1'b0;
      last_acked <= '0;
      last_sent  <= '0;
      sent_cnt   <= '0;
    end else begin
      if (cfg_take) begin
        fsize <= file_size;
      end

      if (state == gbn_pkg::ST_DECIDE) begin
        if (la_we) begin
          last_acked <= la_new;
        end
        if (op == gbn_pkg::OP_START) begin
          active    <= 1'b1;
          last_sent <= '0;
        end
      end

      if (state == gbn_pkg::ST_OFFSET) begin
        sent_cnt <= '0;
      end else if ((state == gbn_pkg::ST_SEND) && out_free) begin
        sent_cnt <= sent_cnt + 1'b1;
        if (rec_last) begin
          last_sent <= cur_seq;
        end
      end

      if ((state == gbn_pkg::ST_FINISH) && out_free) begin
        active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      op  <= gbn_pkg::op_t'(opcode);
      ack <= ack_seq;
    end

    if (state == gbn_pkg::ST_DIVIDE) begin
      quot <= quot_now;
    end

    if (state == gbn_pkg::ST_REMAIN) begin
      rem <= rem_now;
    end

    if (state == gbn_pkg::ST_DECIDE) begin
      rec_count <= cnt_now;
      fin_len   <= fin_len_now;
    end

    // first record of the window: offset = last_acked * PAYLOAD_BYTES
    if (state == gbn_pkg::ST_OFFSET) begin
      cur_seq <= last_acked + 1'b1;
      cur_off <= mul_prod;
    end else if ((state == gbn_pkg::ST_SEND) && out_free) begin
      cur_seq <= cur_seq + 1'b1;
      cur_off <= cur_off + PAY_OFF;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = out_free &&
                    ((state == gbn_pkg::ST_SEND) || (state == gbn_pkg::ST_FINISH));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == gbn_pkg::ST_SEND) begin
        kind        <= gbn_pkg::KIND_SEND;
        seq         <= cur_seq;
        byte_offset <= cur_off;
        length      <= rec_final ? fin_len : PAY_LEN;
        last        <= rec_last;
      end else begin
        kind        <= gbn_pkg::KIND_DONE;
        seq         <= '0;
        byte_offset <= '0;
        length      <= '0;
        last        <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gbn_checker.sv -----
`default_nettype none

module gbn_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       kind,
  input wire logic [gbn_pkg::SEQ_W-1:0]  seq,
  input wire logic [gbn_pkg::LEN_W-1:0]  length,
  input wire logic                       last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seq) && $stable(kind) && $stable(last))
    else $error("stalled result changed");

  // done result carries zeros and closes the event
  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == gbn_pkg::KIND_DONE) |-> last && (seq == '0) && (length == '0))
    else $error("malformed done result");

  // send requests number from 1
  a_send_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == gbn_pkg::KIND_SEND) |-> (seq != '0))
    else $error("send request with sequence 0");

  // an accepted event keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind go_back_n_sender_core gbn_checker u_gbn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .seq       (seq),
  .length    (length),
  .last      (last)
);

`default_nettype wire

// ----- tb/go_back_n_sender_core_tb.sv -----
`timescale 1ns / 1ps

module go_back_n_sender_core_tb;

  localparam int PAYLOAD_BYTES = 512;
  localparam int WINDOW        = 8;
  // Sends per event never exceed the core's output cap
  localparam int SEND_CAP      = (WINDOW < gbn_pkg::MAX_OUT) ? WINDOW : gbn_pkg::MAX_OUT;
  localparam int RESET_CYCLES  = 11;
  // Room for a no-result event still in the sequencer, padded generously
  localparam int QUIET_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    gbn_pkg::kind_t            kind;
    logic [gbn_pkg::SEQ_W-1:0] seq;
    logic [gbn_pkg::OFF_W-1:0] byte_offset;
    logic [gbn_pkg::LEN_W-1:0] length;
    logic                      last;
  } record_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_t;
  // CHK_MODEL: predictor decides; CHK_NONE / CHK_ONE: result typed in the row
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    row_t                       row;
    logic [gbn_pkg::SIZE_W-1:0] size;
    gbn_pkg::op_t               op;
    logic [gbn_pkg::SEQ_W-1:0]  arg;
    chk_t                       chk;
    record_t                    res;
  } step_t;

  localparam record_t NO_RES   = '{gbn_pkg::KIND_SEND, 24'd0, 32'd0, 17'd0, 1'b0};
  localparam record_t DONE_RES = '{gbn_pkg::KIND_DONE, 24'd0, 32'd0, 17'd0, 1'b1};

  localparam int SCRIPT_LEN = 33;

  // Directed part: edges of the fields, every opcode, and the corner cases
  step_t script [SCRIPT_LEN] = '{
    '{ROW_WRITE, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    // events before any start are dropped
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd5,       CHK_NONE,  NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_TIMEOUT, 24'd0,       CHK_NONE,  NO_RES},
    // empty file: one zero-length record
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_ONE,
      '{gbn_pkg::KIND_SEND, 24'd1, 32'd0, 17'd0, 1'b1}},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd1,       CHK_ONE,   DONE_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_NACK,    24'd1,       CHK_NONE,  NO_RES},
    // exact multiple of the payload: trailing empty record
    '{ROW_WRITE, 32'd512,       gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_NACK,    24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd2,       CHK_ONE,   DONE_RES},
    // largest file
    '{ROW_WRITE, 32'hFFFF_FFFF, gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd3,       CHK_NONE,  NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd2,       CHK_NONE,  NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_TIMEOUT, 24'hFF_FFFF, CHK_MODEL, NO_RES},
    // rewind straight to the final record: top offset, 511-byte tail
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_NACK,    24'd8388608, CHK_ONE,
      '{gbn_pkg::KIND_SEND, 24'd8388608, 32'hFFFF_FE00, 17'd511, 1'b1}},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd8388607, CHK_NONE,  NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'hFF_FFFF, CHK_ONE,   DONE_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    // restart while a transfer is open
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd7,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_NACK,    24'hFF_FFFF, CHK_ONE,   DONE_RES},
    // nine records, second window holds only the empty tail
    '{ROW_WRITE, 32'd4096,      gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd8,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_TIMEOUT, 24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd9,       CHK_ONE,   DONE_RES},
    // size grows, then shrinks, under an open transfer
    '{ROW_WRITE, 32'd1000,      gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_WRITE, 32'd100000,    gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_TIMEOUT, 24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_ACK,     24'd8,       CHK_MODEL, NO_RES},
    '{ROW_WRITE, 32'd0,         gbn_pkg::OP_START,   24'd0,       CHK_MODEL, NO_RES},
    '{ROW_EVENT, 32'd0,         gbn_pkg::OP_TIMEOUT, 24'd0,       CHK_ONE,   DONE_RES}
  };

  // DUT ports
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 opcode = gbn_pkg::OP_START;
  logic [gbn_pkg::SEQ_W-1:0]  ack_seq = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       kind;
  logic [gbn_pkg::SEQ_W-1:0]  seq;
  logic [gbn_pkg::OFF_W-1:0]  byte_offset;
  logic [gbn_pkg::LEN_W-1:0]  length;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [gbn_pkg::SIZE_W-1:0] file_size = '0;

  // Sender-side shadow of the window state
  logic [gbn_pkg::SIZE_W-1:0] cur_size = '0;
  logic [gbn_pkg::SEQ_W-1:0]  acked_hi = '0;
  logic [gbn_pkg::SEQ_W-1:0]  sent_hi = '0;
  bit                         xfer_active = 1'b0;

  record_t           awaited [$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       in_idle_pct = 0;
  int unsigned       out_stall_pct = 0;
  logic              hold_go = 1'b0;
  logic              hold_out = 1'b0;

  go_back_n_sender_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .WINDOW        (WINDOW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .ack_seq     (ack_seq),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .seq         (seq),
    .byte_offset (byte_offset),
    .length      (length),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .file_size   (file_size)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  // Record count follows the live size register, capped at the top seq number
  function automatic longint unsigned records_total();
    longint unsigned n;
    n = {32'd0, cur_size} / PAYLOAD_BYTES + 1;
    if (n > 64'(gbn_pkg::SEQ_MAX)) n = 64'(gbn_pkg::SEQ_MAX);
    return n;
  endfunction

  // Queue the send requests for one window starting past the acked point
  function automatic void queue_window();
    longint unsigned total;
    longint unsigned s;
    longint unsigned off;
    longint unsigned len;
    int              n;
    record_t         r;
    total = records_total();
    s = 64'(acked_hi) + 64'd1;
    n = 0;
    while (n < SEND_CAP && s <= total) begin
      off = (s - 1) * PAYLOAD_BYTES;
      len = PAYLOAD_BYTES;
      if (s == total) begin
        // tail record: remainder, clipped when the count saturated
        len = (off <= cur_size) ? cur_size - off : 0;
        if (len > PAYLOAD_BYTES) len = PAYLOAD_BYTES;
      end
      r.kind        = gbn_pkg::KIND_SEND;
      r.seq         = s[gbn_pkg::SEQ_W-1:0];
      r.byte_offset = off[gbn_pkg::OFF_W-1:0];
      r.length      = len[gbn_pkg::LEN_W-1:0];
      r.last        = (n == SEND_CAP - 1) || (s == total);
      awaited.push_back(r);
      n++;
      s++;
    end
    if (n > 0) sent_hi = gbn_pkg::SEQ_W'(s - 1);
  endfunction

  function automatic void queue_done();
    awaited.push_back(DONE_RES);
    xfer_active = 1'b0;
  endfunction

  // Apply one event to the shadow state; returns 0 when the core drops it
  function automatic bit predict_event(gbn_pkg::op_t op, logic [gbn_pkg::SEQ_W-1:0] arg);
    if (op == gbn_pkg::OP_START) begin
      xfer_active = 1'b1;
      acked_hi    = '0;
      sent_hi     = '0;
      queue_window();
      return 1'b1;
    end
    if (!xfer_active) return 1'b0;
    case (op)
      gbn_pkg::OP_ACK: begin
        if (arg <= acked_hi) return 1'b0;
        acked_hi = arg;
        if (acked_hi >= records_total()) queue_done();
        else if (acked_hi == sent_hi) queue_window();
      end
      gbn_pkg::OP_NACK: begin
        // rewind to one below the nacked record, floor at zero
        acked_hi = (arg != '0) ? arg - 1'b1 : '0;
        if (acked_hi >= records_total()) queue_done();
        else queue_window();
      end
      default: begin
        if (acked_hi >= records_total()) queue_done();
        else queue_window();
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Entered at a clock edge; valid stays high across back-to-back transactions
  task automatic drive_event(input gbn_pkg::op_t op, input logic [gbn_pkg::SEQ_W-1:0] arg);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    ack_seq  <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain: every result back, then room for a trailing no-result event
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [gbn_pkg::SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    file_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_size = value;
  endtask

  // Mostly small files so transfers finish; a few huge ones for wide offsets
  function automatic logic [gbn_pkg::SIZE_W-1:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom_range(12000, 0);
    if (pick < 75) return PAYLOAD_BYTES * $urandom_range(24, 0);
    if (pick < 90) return $urandom_range(200000, 0);
    return $urandom();
  endfunction

  // Mostly a well-behaved receiver (cumulative acks), plus rewinds,
  // timeouts, restarts, stale acks and random noise
  task automatic random_event(output bit eff);
    int unsigned               pick;
    gbn_pkg::op_t              op;
    logic [gbn_pkg::SEQ_W-1:0] arg;
    pick = $urandom_range(99);
    arg  = gbn_pkg::SEQ_W'($urandom());
    op   = gbn_pkg::OP_TIMEOUT;
    if (!xfer_active) begin
      op = (pick < 80) ? gbn_pkg::OP_START : gbn_pkg::op_t'($urandom_range(3, 1));
    end else if (pick < 50) begin
      op  = gbn_pkg::OP_ACK;
      arg = sent_hi;
    end else if (pick < 62) begin
      op  = gbn_pkg::OP_ACK;
      arg = gbn_pkg::SEQ_W'($urandom_range(sent_hi, acked_hi + 1));
    end else if (pick < 72) begin
      op  = gbn_pkg::OP_NACK;
      arg = gbn_pkg::SEQ_W'($urandom_range(sent_hi + 1, 1));
    end else if (pick < 82) begin
      op = gbn_pkg::OP_TIMEOUT;
    end else if (pick < 88) begin
      op = gbn_pkg::OP_START;
    end else if (pick < 96) begin
      op = gbn_pkg::op_t'($urandom_range(3, 1));
    end else begin
      op  = gbn_pkg::OP_ACK;
      arg = gbn_pkg::SEQ_W'($urandom_range(acked_hi, 0));
    end
    eff = predict_event(op, arg);
    drive_event(op, arg);
  endtask

  task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
                           input int unsigned n_items, input bit hold);
    bit          eff;
    int unsigned n;
    wait_quiet();
    in_idle_pct = in_pct;
    out_stall_pct <= out_pct;
    write_size(pick_size());
    if (hold) begin
      // receiver goes dark while the sender keeps pushing
      hold_go <= 1'b1;
      @(posedge clk);
      hold_go <= 1'b0;
    end
    n = 0;
    while (n < n_items) begin
      random_event(eff);
      if (eff) n++;
    end
  endtask

  // Long receiver hold-off, timed on its own
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    end
  end

  // Receiver: random stalls and in-order compare of every result transaction
  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_out || ($urandom_range(99) < out_stall_pct);
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("unexpected result: kind %0d seq %0h", kind, seq);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0h, got %0h", want.kind, kind);
            mismatches++;
          end
          if (seq !== want.seq) begin
            $error("seq: expected %0h, got %0h", want.seq, seq);
            mismatches++;
          end
          if (byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %0h, got %0h", want.byte_offset, byte_offset);
            mismatches++;
          end
          if (length !== want.length) begin
            $error("length: expected %0h, got %0h", want.length, length);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0h, got %0h", want.last, last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("go_back_n_sender_core regression: fail");
      $finish;
    end
  end

  initial begin
    bit          eff;
    int unsigned base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].row == ROW_WRITE) begin
        wait_quiet();
        write_size(script[i].size);
      end else begin
        base = awaited.size();
        eff  = predict_event(script[i].op, script[i].arg);
        if (script[i].chk != CHK_MODEL) begin
          // typed row: keep the state update, swap in the hand-written result
          while (awaited.size() > base) void'(awaited.pop_back());
          if (script[i].chk == CHK_ONE) awaited.push_back(script[i].res);
        end
        drive_event(script[i].op, script[i].arg);
      end
    end

    run_phase(0, 0, 48, 1'b0);
    run_phase(53, 0, 48, 1'b0);
    run_phase(0, 53, 48, 1'b0);
    run_phase(28, 28, 48, 1'b0);
    run_phase(0, 0, 16, 1'b1);

    wait_quiet();
    if (mismatches == 0) begin
      $display("go_back_n_sender_core regression: pass");
    end else begin
      $display("go_back_n_sender_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gbn_pkg.sv
hw/rtl/go_back_n_sender_core.sv
hw/rtl/gbn_checker.sv
tb/go_back_n_sender_core_tb.sv
